>>> src/mdag_pkg.sv
package mdag_pkg;

	localparam int ID_W   = 4;
	localparam int SLOT_W = 3;
	localparam int CNT_W  = 4;
	localparam int VAL_W  = 32;
	localparam int ADDR_W = 32;

	typedef enum logic [1:0] {
		OP_HEADER = 2'd0,
		OP_BOUNDS = 2'd1,
		OP_INDEX  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ID_W-1:0]   id;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  cnt;
		logic [VAL_W-1:0]  v1;
		logic [VAL_W-1:0]  v2;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [ID_W-1:0]   id;
	} res_t;

endpackage

>>> src/mdag_fifo.sv
module mdag_fifo import mdag_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + CW'(1);
				end
				2'b01: begin
					cnt_q <= cnt_q - CW'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

>>> src/mdag_front.sv
module mdag_front import mdag_pkg::*; #(
	parameter int NUM_ARRAYS = 16,
	parameter int MAX_DIMS   = 8
) (
	input  logic              push,
	input  logic              cmd_full,
	input  logic [1:0]        operation,
	input  logic [ID_W-1:0]   array_id,
	input  logic [SLOT_W-1:0] dim_slot,
	input  logic [CNT_W-1:0]  dim_count,
	input  logic [VAL_W-1:0]  first_value,
	input  logic [VAL_W-1:0]  second_value,
	output logic              cmd_push,
	output cmd_t              cmd
);

	op_t  op;
	logic keep;

	assign op = op_t'(operation);

	always_comb begin
		keep = 1'b0;
		if (int'(array_id) < NUM_ARRAYS) begin
			unique case (op)
				OP_HEADER: keep = 1'b1;
				OP_BOUNDS: keep = (int'(dim_slot) < MAX_DIMS);
				OP_INDEX:  keep = 1'b1;
				OP_NONE:   keep = 1'b0;
				default:   keep = 1'b0;
			endcase
		end
	end

	// dropped beats are taken from the port but never queued
	assign cmd_push = push && !cmd_full && keep;

	always_comb begin
		cmd.op   = op;
		cmd.id   = array_id;
		cmd.slot = dim_slot;
		cmd.cnt  = dim_count;
		cmd.v1   = first_value;
		cmd.v2   = second_value;
	end

endmodule

>>> src/mdag_back.sv
module mdag_back import mdag_pkg::*; #(
	parameter int NUM_ARRAYS = 16,
	parameter int MAX_DIMS   = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_empty,
	output logic cmd_pop,
	output res_t res,
	output logic res_push,
	input  logic res_full
);

	localparam int DW      = DATA_WIDTH;
	localparam int SLOTS   = NUM_ARRAYS * MAX_DIMS;
	localparam int ID_AW   = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
	localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DCW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DIMS_W  = $clog2(MAX_DIMS + 1);
	localparam int CMPW    = (DIMS_W > CNT_W) ? DIMS_W : CNT_W;
	localparam int DIGIT_W = (DW <= 32) ? DW : (DW + 3) / 4;
	localparam int NSTEP   = (DW + DIGIT_W - 1) / DIGIT_W;
	localparam int MB_W    = NSTEP * DIGIT_W;
	localparam int ML_W    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_MAC,
		ST_SCALE,
		ST_EMIT
	} state_t;

	logic [DW-1:0]     base_mem [NUM_ARRAYS];
	logic [DW-1:0]     esz_mem  [NUM_ARRAYS];
	logic [DIMS_W-1:0] dims_mem [NUM_ARRAYS];
	logic [DW-1:0]     low_mem  [SLOTS];
	logic [DW-1:0]     ext_mem  [SLOTS];

	logic [DW-1:0]     base_rd_q;
	logic [DW-1:0]     esz_rd_q;
	logic [DIMS_W-1:0] dims_rd_q;
	logic [DW-1:0]     low_rd_q;
	logic [DW-1:0]     ext_rd_q;

	state_t            state_q;
	logic [DW-1:0]     acc_q;
	logic [DCW-1:0]    dim_q;
	logic [DCW-1:0]    d_q;
	logic [DW-1:0]     idx_v1_q;
	logic [ID_W-1:0]   idx_id_q;
	logic [DW-1:0]     addr_q;
	logic [DW-1:0]     mul_a_q;
	logic [MB_W-1:0]   mul_b_q;
	logic [DW-1:0]     mul_p_q;
	logic [ML_W-1:0]   mul_left_q;

	logic              wr_hdr;
	logic              wr_bnd;
	logic              rd_idx;
	logic [ID_AW-1:0]  id_a;
	logic [DCW-1:0]    d_cur;
	logic [SLOT_AW-1:0] slot_wr;
	logic [SLOT_AW-1:0] slot_rd;
	logic [DW-1:0]     v1_w;
	logic [DW-1:0]     v2_w;
	logic [DW-1:0]     ext_w;
	logic [CMPW-1:0]   cnt_x;
	logic [DIMS_W-1:0] cnt_c;
	logic [DW+DIGIT_W-1:0] mul_pp;
	logic [DW-1:0]     mul_sum;
	logic              is_last;

	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty;
	assign wr_hdr  = cmd_pop && (cmd.op == OP_HEADER);
	assign wr_bnd  = cmd_pop && (cmd.op == OP_BOUNDS);
	assign rd_idx  = cmd_pop && (cmd.op == OP_INDEX);

	assign id_a  = ID_AW'(cmd.id);
	assign d_cur = (int'(dim_q) >= MAX_DIMS) ? DCW'(MAX_DIMS - 1) : dim_q;
	assign slot_wr = SLOT_AW'(id_a) * SLOT_AW'(MAX_DIMS) + SLOT_AW'(cmd.slot);
	assign slot_rd = SLOT_AW'(id_a) * SLOT_AW'(MAX_DIMS) + SLOT_AW'(d_cur);

	assign v1_w  = DW'($signed(cmd.v1));
	assign v2_w  = DW'($signed(cmd.v2));
	assign ext_w = v2_w - v1_w + DW'(1);
	assign cnt_x = CMPW'(cmd.cnt);

	always_comb begin
		priority if (cnt_x == '0) begin
			cnt_c = DIMS_W'(1);
		end else if (cnt_x > CMPW'(MAX_DIMS)) begin
			cnt_c = DIMS_W'(MAX_DIMS);
		end else begin
			cnt_c = DIMS_W'(cnt_x);
		end
	end

	// one digit of the multiplier per cycle, product folded into the running sum
	assign mul_pp  = mul_a_q * mul_b_q[DIGIT_W-1:0];
	assign mul_sum = mul_p_q + mul_pp[DW-1:0];
	assign is_last = (int'(d_q) + 1 >= int'(dims_rd_q));

	assign res_push    = (state_q == ST_EMIT) && !res_full;
	assign res.address = ADDR_W'(addr_q);
	assign res.id      = idx_id_q;

	always_ff @(posedge clk) begin
		if (wr_hdr) begin
			base_mem[id_a] <= v1_w;
			esz_mem[id_a]  <= v2_w;
			dims_mem[id_a] <= cnt_c;
		end
		if (wr_bnd) begin
			low_mem[slot_wr] <= v1_w;
			ext_mem[slot_wr] <= ext_w;
		end
		if (rd_idx) begin
			base_rd_q <= base_mem[id_a];
			esz_rd_q  <= esz_mem[id_a];
			dims_rd_q <= dims_mem[id_a];
			low_rd_q  <= low_mem[slot_rd];
			ext_rd_q  <= ext_mem[slot_rd];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			acc_q      <= '0;
			dim_q      <= '0;
			d_q        <= '0;
			idx_v1_q   <= '0;
			idx_id_q   <= '0;
			addr_q     <= '0;
			mul_a_q    <= '0;
			mul_b_q    <= '0;
			mul_p_q    <= '0;
			mul_left_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rd_idx) begin
						idx_v1_q <= v1_w;
						idx_id_q <= cmd.id;
						d_q      <= d_cur;
						state_q  <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					mul_a_q    <= acc_q;
					mul_b_q    <= MB_W'(ext_rd_q);
					mul_p_q    <= idx_v1_q - low_rd_q;
					mul_left_q <= ML_W'(NSTEP - 1);
					state_q    <= ST_MAC;
				end
				ST_MAC: begin
					if (mul_left_q != '0) begin
						mul_a_q    <= mul_a_q << DIGIT_W;
						mul_b_q    <= mul_b_q >> DIGIT_W;
						mul_p_q    <= mul_sum;
						mul_left_q <= mul_left_q - ML_W'(1);
					end else if (is_last) begin
						// scale by element size and add base
						mul_a_q    <= esz_rd_q;
						mul_b_q    <= MB_W'(mul_sum);
						mul_p_q    <= base_rd_q;
						mul_left_q <= ML_W'(NSTEP - 1);
						state_q    <= ST_SCALE;
					end else begin
						acc_q   <= mul_sum;
						dim_q   <= d_q + DCW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_SCALE: begin
					mul_a_q    <= mul_a_q << DIGIT_W;
					mul_b_q    <= mul_b_q >> DIGIT_W;
					mul_p_q    <= mul_sum;
					mul_left_q <= mul_left_q - ML_W'(1);
					if (mul_left_q == '0) begin
						addr_q  <= mul_sum;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!res_full) begin
						acc_q   <= '0;
						dim_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/multidim_array_address_generator.sv
// channel   handshake        payload
// input     push / full      operation, array_id, dim_slot, dim_count,
//                            first_value, second_value
// result    empty / pop      address, result_array_id
//
// header and bounds beats end in ST_IDLE; an index beat runs ST_LOOK and S steps
// of ST_MAC, the last index of a query then S steps of ST_SCALE and ST_EMIT, with
// S = digit steps of the shared multiplier (1 up to DATA_WIDTH 32, else 4)
// a two-entry queue on each side lets input and result stall independently
// reset clears both queues and the running query; descriptor tables keep no reset
module multidim_array_address_generator import mdag_pkg::*; #(
	parameter int NUM_ARRAYS = 16,
	parameter int MAX_DIMS   = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [1:0]               operation,
	input  logic [ID_W-1:0]          array_id,
	input  logic [SLOT_W-1:0]        dim_slot,
	input  logic [CNT_W-1:0]         dim_count,
	input  logic signed [VAL_W-1:0]  first_value,
	input  logic signed [VAL_W-1:0]  second_value,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [ADDR_W-1:0] address,
	output logic [ID_W-1:0]          result_array_id
);

	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;
	res_t res_in;
	res_t res_out;
	logic res_push;
	logic res_full;

	mdag_front #(
		.NUM_ARRAYS(NUM_ARRAYS),
		.MAX_DIMS  (MAX_DIMS)
	) u_front (
		.push        (push),
		.cmd_full    (cmd_full),
		.operation   (operation),
		.array_id    (array_id),
		.dim_slot    (dim_slot),
		.dim_count   (dim_count),
		.first_value (first_value),
		.second_value(second_value),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	mdag_fifo #(
		.W($bits(cmd_t))
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty)
	);

	mdag_back #(
		.NUM_ARRAYS(NUM_ARRAYS),
		.MAX_DIMS  (MAX_DIMS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res      (res_in),
		.res_push (res_push),
		.res_full (res_full)
	);

	mdag_fifo #(
		.W($bits(res_t))
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign full            = cmd_full;
	assign address         = res_out.address;
	assign result_array_id = res_out.id;

	a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command beat queued into a full queue");

	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("back end took a command from an empty queue");

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result beat pushed into a full queue");

endmodule

>>> bench/multidim_array_address_generator_tb.sv
module multidim_array_address_generator_tb;
	import mdag_pkg::*;

	localparam int PLAN_LEN    = 22;
	localparam int TOTAL_BEATS = 650;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		op_t               op;
		logic [ID_W-1:0]   id;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  cnt;
		logic [VAL_W-1:0]  v1;
		logic [VAL_W-1:0]  v2;
		bit                typed;
		logic [ADDR_W-1:0] addr;
	} row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	logic [1:0]               operation;
	logic [ID_W-1:0]          array_id;
	logic [SLOT_W-1:0]        dim_slot;
	logic [CNT_W-1:0]         dim_count;
	logic signed [VAL_W-1:0]  first_value;
	logic signed [VAL_W-1:0]  second_value;
	logic                     empty;
	logic                     pop;
	logic signed [ADDR_W-1:0] address;
	logic [ID_W-1:0]          result_array_id;

	// descriptor copy and running query
	logic [VAL_W-1:0]  base_mem   [16];
	logic [VAL_W-1:0]  esize_mem  [16];
	logic [CNT_W-1:0]  dims_mem   [16];
	logic [VAL_W-1:0]  lower_mem  [128];
	logic [VAL_W-1:0]  extent_mem [128];
	logic [VAL_W-1:0]  offset_acc;
	logic [SLOT_W-1:0] dim_ctr;

	res_t address_due [$];
	res_t want;
	row_t plan [PLAN_LEN];
	int   mismatch_count;
	int   cycle_count;
	int   beats_sent;
	bit   steady;

	multidim_array_address_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.array_id(array_id),
		.dim_slot(dim_slot),
		.dim_count(dim_count),
		.first_value(first_value),
		.second_value(second_value),
		.empty(empty),
		.pop(pop),
		.address(address),
		.result_array_id(result_array_id)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic predict_address(input cmd_t c, output bit done, output res_t r);
		logic [6:0]       pos;
		logic [CNT_W-1:0] dims;
		done = 1'b0;
		r    = '0;
		case (c.op)
			OP_HEADER: begin
				base_mem[c.id]  = c.v1;
				esize_mem[c.id] = c.v2;
				if (c.cnt == 0)
					dims_mem[c.id] = 4'd1;
				else if (c.cnt > 4'd8)
					dims_mem[c.id] = 4'd8;
				else
					dims_mem[c.id] = c.cnt;
			end
			OP_BOUNDS: begin
				pos             = {c.id, c.slot};
				lower_mem[pos]  = c.v1;
				extent_mem[pos] = c.v2 - c.v1 + 32'd1;
			end
			OP_INDEX: begin
				dims       = (dims_mem[c.id] == 0) ? 4'd1 : dims_mem[c.id];
				pos        = {c.id, dim_ctr};
				offset_acc = offset_acc * extent_mem[pos] + (c.v1 - lower_mem[pos]);
				if (int'(dim_ctr) + 1 >= int'(dims)) begin
					done       = 1'b1;
					r.address  = base_mem[c.id] + esize_mem[c.id] * offset_acc;
					r.id       = c.id;
					offset_acc = '0;
					dim_ctr    = '0;
				end else begin
					dim_ctr = dim_ctr + 3'd1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_beat(input cmd_t c, input bit typed, input logic [ADDR_W-1:0] typed_addr);
		bit   done;
		res_t r;
		while (!steady && $urandom_range(99) < 32) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push         <= 1'b1;
		operation    <= c.op;
		array_id     <= c.id;
		dim_slot     <= c.slot;
		dim_count    <= c.cnt;
		first_value  <= c.v1;
		second_value <= c.v2;
		do @(posedge clk); while (full);
		predict_address(c, done, r);
		if (done) begin
			if (typed)
				r.address = typed_addr;
			address_due = {address_due, r};
		end
		if (c.op != OP_NONE)
			beats_sent++;
		@(negedge clk);
	endtask

	task automatic pick_bounds(output logic [VAL_W-1:0] lo, output logic [VAL_W-1:0] hi);
		case ($urandom_range(9))
			0: begin
				lo = $urandom;
				hi = $urandom;
			end
			1: begin
				lo = 32'h8000_0000;
				hi = lo + $urandom_range(0, 15);
			end
			2: begin
				lo = 32'h7fff_fff0;
				hi = lo + $urandom_range(0, 31);
			end
			default: begin
				lo = $urandom_range(0, 40) - 20;
				hi = lo + $urandom_range(0, 15);
			end
		endcase
	endtask

	function automatic logic [VAL_W-1:0] pick_index(input logic [ID_W-1:0] id);
		logic [6:0]       pos;
		logic [VAL_W-1:0] span;
		pos  = {id, dim_ctr};
		span = extent_mem[pos];
		if ($urandom_range(99) < 25)
			return $urandom;
		if (span == 0 || span > 1000)
			span = 1000;
		return lower_mem[pos] + $urandom_range(0, span - 1);
	endfunction

	initial begin
		cmd_t c;
		int   n;
		int   roll;
		push         = 1'b0;
		operation    = '0;
		array_id     = '0;
		dim_slot     = '0;
		dim_count    = '0;
		first_value  = '0;
		second_value = '0;
		arst_n       = 1'b0;
		steady       = 1'b0;
		offset_acc   = '0;
		dim_ctr      = '0;
		plan = '{
			'{OP_HEADER, 4'd0,  3'd0, 4'd1,  32'h0000_1000, 32'd4,         1'b0, 32'h0},
			'{OP_BOUNDS, 4'd0,  3'd0, 4'd0,  32'd0,         32'd9,         1'b0, 32'h0},
			'{OP_INDEX,  4'd0,  3'd0, 4'd0,  32'd3,         32'd0,         1'b1, 32'h0000_100c},
			// zero dimension count acts as one
			'{OP_HEADER, 4'd15, 3'd7, 4'd0,  32'h7fff_ffff, 32'd1,         1'b0, 32'h0},
			'{OP_BOUNDS, 4'd15, 3'd0, 4'd15, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0},
			'{OP_INDEX,  4'd15, 3'd7, 4'd15, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, 32'h7fff_fffe},
			'{OP_HEADER, 4'd3,  3'd0, 4'd2,  32'h0000_0100, 32'd8,         1'b0, 32'h0},
			'{OP_BOUNDS, 4'd3,  3'd0, 4'd0,  32'hffff_ffff, 32'd1,         1'b0, 32'h0},
			'{OP_BOUNDS, 4'd3,  3'd1, 4'd0,  32'd10,        32'd14,        1'b0, 32'h0},
			// unused operation is dropped
			'{OP_NONE,   4'd3,  3'd5, 4'd9,  32'd12,        32'd12,        1'b0, 32'h0},
			'{OP_INDEX,  4'd3,  3'd0, 4'd0,  32'd1,         32'd0,         1'b0, 32'h0},
			'{OP_INDEX,  4'd3,  3'd0, 4'd0,  32'd12,        32'd0,         1'b1, 32'h0000_0160},
			'{OP_BOUNDS, 4'd3,  3'd7, 4'd0,  32'hffff_fffb, 32'd5,         1'b0, 32'h0},
			// count above the limit clamps to eight
			'{OP_HEADER, 4'd3,  3'd0, 4'd15, 32'hffff_fff0, 32'hffff_fffc, 1'b0, 32'h0},
			'{OP_INDEX,  4'd3,  3'd0, 4'd0,  32'd0,         32'd0,         1'b0, 32'h0},
			// descriptor write mid-query leaves the query alone
			'{OP_BOUNDS, 4'd0,  3'd1, 4'd0,  32'd0,         32'd0,         1'b0, 32'h0},
			// switch to a one-dimension array mid-query
			'{OP_INDEX,  4'd0,  3'd0, 4'd0,  32'd5,         32'd0,         1'b0, 32'h0},
			'{OP_HEADER, 4'd8,  3'd0, 4'd8,  32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0},
			'{OP_HEADER, 4'd10, 3'd0, 4'd1,  32'd0,         32'h8000_0000, 1'b0, 32'h0},
			'{OP_BOUNDS, 4'd10, 3'd0, 4'd0,  32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0},
			'{OP_INDEX,  4'd10, 3'd0, 4'd0,  32'h8000_0001, 32'd0,         1'b1, 32'h0},
			'{OP_INDEX,  4'd0,  3'd0, 4'd0,  32'hffff_ffff, 32'd0,         1'b1, 32'h0000_0ffc}
		};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			c = '{plan[i].op, plan[i].id, plan[i].slot, plan[i].cnt, plan[i].v1, plan[i].v2};
			send_beat(c, plan[i].typed, plan[i].addr);
		end

		// fill every descriptor so later queries never touch an unwritten entry
		for (int a = 0; a < 16; a++) begin
			c = '{OP_HEADER, 4'(a), 3'($urandom), 4'($urandom_range(1, 4)), $urandom,
				32'($urandom_range(1, 16))};
			send_beat(c, 1'b0, '0);
			for (int s = 0; s < 8; s++) begin
				c = '{OP_BOUNDS, 4'(a), 3'(s), 4'($urandom), 32'd0, 32'd0};
				pick_bounds(c.v1, c.v2);
				send_beat(c, 1'b0, '0);
			end
		end

		while (beats_sent < TOTAL_BEATS) begin
			steady = (beats_sent >= 350 && beats_sent < 450);
			roll   = $urandom_range(99);
			if (roll < 55) begin
				c.id = 4'($urandom);
				n    = (dims_mem[c.id] == 0) ? 1 : int'(dims_mem[c.id]);
				for (int k = 0; k < n; k++) begin
					roll = $urandom_range(99);
					if (roll < 4)
						break;
					if (roll < 14) begin
						cmd_t w;
						w = '{OP_BOUNDS, 4'($urandom), 3'($urandom), 4'($urandom), 32'd0, 32'd0};
						pick_bounds(w.v1, w.v2);
						send_beat(w, 1'b0, '0);
					end
					c.op   = OP_INDEX;
					c.slot = 3'($urandom);
					c.cnt  = 4'($urandom);
					c.v2   = $urandom;
					if (roll >= 14 && roll < 22) begin
						cmd_t sw;
						sw    = c;
						sw.id = 4'($urandom);
						sw.v1 = pick_index(sw.id);
						send_beat(sw, 1'b0, '0);
					end else begin
						c.v1 = pick_index(c.id);
						send_beat(c, 1'b0, '0);
					end
				end
			end else if (roll < 70) begin
				c.op   = OP_HEADER;
				c.id   = 4'($urandom);
				c.slot = 3'($urandom);
				c.cnt  = ($urandom_range(99) < 80) ? 4'($urandom_range(1, 4)) : 4'($urandom);
				c.v1   = ($urandom_range(1) == 1) ? $urandom : 32'($urandom_range(0, 255)) << 4;
				case ($urandom_range(4))
					0: c.v2 = 32'd1;
					1: c.v2 = 32'd4;
					2: c.v2 = 32'd8;
					3: c.v2 = 32'hffff_fffc;
					default: c.v2 = $urandom;
				endcase
				send_beat(c, 1'b0, '0);
			end else if (roll < 90) begin
				c = '{OP_BOUNDS, 4'($urandom), 3'($urandom), 4'($urandom), 32'd0, 32'd0};
				pick_bounds(c.v1, c.v2);
				send_beat(c, 1'b0, '0);
			end else begin
				c = '{OP_NONE, 4'($urandom), 3'($urandom), 4'($urandom), $urandom, $urandom};
				send_beat(c, 1'b0, '0);
			end
		end
		steady = 1'b0;
		push <= 1'b0;

		while (address_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			pop <= steady || ($urandom_range(99) >= 32);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (address_due.size() == 0) begin
				$error("result beat with nothing expected: address %h, result_array_id %0d",
					address, result_array_id);
				mismatch_count++;
			end else begin
				want = address_due.pop_front();
				if (address !== want.address) begin
					$error("address: expected %h, got %h", want.address, address);
					mismatch_count++;
				end
				if (result_array_id !== want.id) begin
					$error("result_array_id: expected %0d, got %0d", want.id, result_array_id);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule

>>> multidim_array_address_generator.f
src/mdag_pkg.sv
src/mdag_fifo.sv
src/mdag_front.sv
src/mdag_back.sv
src/multidim_array_address_generator.sv
bench/multidim_array_address_generator_tb.sv
